// ----- rtl/bracket_range_balance_checker_macros.svh -----
// Assertion macros shared by the bracket range balance checker.
`ifndef BRACKET_RANGE_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_RANGE_BALANCE_CHECKER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BRBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BRBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/brbc_pkg.sv -----
`default_nettype none

package brbc_pkg;

   // Widths of the beat fields.
   localparam int ACTION_W = 2;
   localparam int POS_W    = 10;

   // A walk covers at most 2**POS_W brackets, so the depth never exceeds that count.
   localparam int DEPTH_W  = POS_W + 1;

   localparam int MAX_LEN_DEFAULT = 1024;

   // Stored code of an open bracket; a close bracket is the other value.
   localparam logic OPEN_BRACKET = 1'b0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_SWAP  = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

endpackage

`default_nettype wire

// ----- rtl/bracket_range_balance_checker.sv -----
// Channel  | Ports                                     | Handshake
// ---------+-------------------------------------------+------------------------------
// request  | req_action, req_first_pos, req_last_pos,  | taken when start && !busy
//          | req_bracket_value                         |
// response | rsp_balanced, rsp_bad_range               | rsp_valid for one cycle only
//
// A load passes through ST_LOAD with busy high after it is taken, and a swap through
// ST_SWAP_RD_A, ST_SWAP_RD_B, ST_SWAP_WR_A and ST_SWAP_WR_B. A query keeps busy high
// while the walk reads one bracket per cycle from the single read port of the bracket
// memory; a walk that goes below zero stops early. The result beat appears in the same
// cycle as busy falls. A query with a bad range raises no busy and answers in the next cycle.
// Reset is synchronous and clears the control state only: the bracket memory keeps
// its contents and is undefined until written. The receiver cannot stall the results.
`default_nettype none

`include "bracket_range_balance_checker_macros.svh"

module bracket_range_balance_checker #(
   parameter int MAX_LEN = brbc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [brbc_pkg::ACTION_W-1:0] req_action,
   input  logic [brbc_pkg::POS_W-1:0]    req_first_pos,
   input  logic [brbc_pkg::POS_W-1:0]    req_last_pos,
   input  logic                          req_bracket_value,
   output logic                          rsp_valid,
   output logic                          rsp_balanced,
   output logic                          rsp_bad_range
);

   import brbc_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LEN);

   // Load and swap run through dedicated states; a query walks in ST_WALK.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SWAP_RD_A,
      ST_SWAP_RD_B,
      ST_SWAP_WR_A,
      ST_SWAP_WR_B,
      ST_WALK
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   first_ff, first_in;
   logic [POS_W-1:0]   last_ff, last_in;
   logic               value_ff, value_in;
   logic [POS_W-1:0]   ptr_ff, ptr_in;
   logic               issued_all_ff, issued_all_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rd_last_ff, rd_last_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               save_ff, save_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_balanced_ff, rsp_balanced_in;
   logic               rsp_bad_ff, rsp_bad_in;

   // Bracket memory: one write port and one read port, read data registered.
   logic               bracket_mem [MAX_LEN];
   logic               rd_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic               mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   logic               accept;
   logic               first_ok;
   logic               last_ok;
   logic               walk_fail;
   logic               issue;

   assign accept   = start && !busy;
   assign first_ok = 32'(req_first_pos) < MAX_LEN;
   assign last_ok  = 32'(req_last_pos) < MAX_LEN;

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_balanced  = rsp_balanced_ff;
   assign rsp_bad_range = rsp_bad_ff;

   // The sequencing keeps every read clear of any write still pending to the
   // same entry: a swap reads both entries before it writes either, and a new
   // beat is only taken once the previous write has landed.
   always_comb begin
      state_in        = state_ff;
      first_in        = first_ff;
      last_in         = last_ff;
      value_in        = value_ff;
      ptr_in          = ptr_ff;
      issued_all_in   = issued_all_ff;
      rd_pend_in      = 1'b0;
      rd_last_in      = 1'b0;
      depth_in        = depth_ff;
      save_in         = save_ff;
      rsp_valid_in    = 1'b0;
      rsp_balanced_in = rsp_balanced_ff;
      rsp_bad_in      = rsp_bad_ff;
      mem_we          = 1'b0;
      mem_waddr       = ADDR_W'(first_ff);
      mem_wdata       = value_ff;
      mem_raddr       = ADDR_W'(ptr_ff);
      walk_fail       = 1'b0;
      issue           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               first_in = req_first_pos;
               last_in  = req_last_pos;
               value_in = req_bracket_value;
               case (action_type'(req_action))
                  ACT_LOAD: begin
                     if (first_ok) begin
                        state_in = ST_LOAD;
                     end
                  end
                  ACT_SWAP: begin
                     if (first_ok && last_ok) begin
                        state_in = ST_SWAP_RD_A;
                     end
                  end
                  ACT_QUERY: begin
                     if ((req_first_pos > req_last_pos) || !first_ok || !last_ok) begin
                        rsp_valid_in    = 1'b1;
                        rsp_balanced_in = 1'b0;
                        rsp_bad_in      = 1'b1;
                     end else begin
                        state_in      = ST_WALK;
                        ptr_in        = req_first_pos;
                        issued_all_in = 1'b0;
                        depth_in      = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SWAP_RD_A: begin
            mem_raddr = ADDR_W'(first_ff);
            state_in  = ST_SWAP_RD_B;
         end
         ST_SWAP_RD_B: begin
            mem_raddr = ADDR_W'(last_ff);
            save_in   = rd_ff;
            state_in  = ST_SWAP_WR_A;
         end
         ST_SWAP_WR_A: begin
            mem_we    = 1'b1;
            mem_wdata = rd_ff;
            state_in  = ST_SWAP_WR_B;
         end
         ST_SWAP_WR_B: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(last_ff);
            mem_wdata = save_ff;
            state_in  = ST_IDLE;
         end
         ST_WALK: begin
            // Read side: one address per cycle until the range end is issued.
            issue = !issued_all_ff;
            if (issue) begin
               ptr_in     = ptr_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_last_in = (ptr_ff == last_ff);
               if (ptr_ff == last_ff) begin
                  issued_all_in = 1'b1;
               end
            end
            // Depth side: consume the bracket read in the previous cycle.
            if (rd_pend_ff) begin
               if (rd_ff == OPEN_BRACKET) begin
                  depth_in = depth_ff + 1'b1;
               end else if (depth_ff == '0) begin
                  walk_fail = 1'b1;
               end else begin
                  depth_in = depth_ff - 1'b1;
               end
               if (walk_fail || rd_last_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_balanced_in = !walk_fail && (depth_in == '0);
                  rsp_bad_in      = 1'b0;
                  rd_pend_in      = 1'b0;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff        <= first_in;
      last_ff         <= last_in;
      value_ff        <= value_in;
      ptr_ff          <= ptr_in;
      issued_all_ff   <= issued_all_in;
      rd_last_ff      <= rd_last_in;
      save_ff         <= save_in;
      rsp_balanced_ff <= rsp_balanced_in;
      rsp_bad_ff      <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bracket_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= bracket_mem[mem_raddr];
   end

   `BRBC_ASSERT_NOW(a_rsp_flags_exclusive, clock, reset, rsp_valid, !(rsp_balanced && rsp_bad_range), "balanced and bad range raised together")
   `BRBC_ASSERT_NEXT(a_reversed_range_answer, clock, reset, accept && (req_action == ACT_QUERY) && (req_first_pos > req_last_pos), rsp_valid && rsp_bad_range && !busy, "reversed range not answered at once")
   `BRBC_ASSERT_NOW(a_write_only_when_owed, clock, reset, mem_we, (state_ff == ST_LOAD) || (state_ff == ST_SWAP_WR_A) || (state_ff == ST_SWAP_WR_B), "bracket memory written outside load or swap")
   `BRBC_ASSERT_NOW(a_read_pending_in_walk, clock, reset, rd_pend_ff, state_ff == ST_WALK, "walk read data pending outside the walk")

endmodule

`default_nettype wire

// ----- tb/balance_verdict_checker.sv -----
`default_nettype none

module balance_verdict_checker
   import brbc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [POS_W-1:0]    req_first_pos,
   input  wire logic [POS_W-1:0]    req_last_pos,
   input  wire logic                req_bracket_value,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_balanced,
   input  wire logic                rsp_bad_range,
   output int                       failures,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 1 << POS_W;

   typedef struct packed {
      logic balanced;
      logic bad_range;
   } verdict_type;

   logic        bracket_copy [STORE_DEPTH];
   verdict_type awaited_verdicts [$];
   int          mismatch_count = 0;

   // Walks the copy of the store from lo to hi and gives the verdict of a query.
   function automatic verdict_type walk_balance(input logic [POS_W-1:0] lo,
                                                input logic [POS_W-1:0] hi);
      verdict_type v;
      int          depth;
      v.balanced  = 1'b0;
      v.bad_range = 1'b1;
      if (lo > hi) begin
         return v;
      end
      v.bad_range = 1'b0;
      v.balanced  = 1'b1;
      depth = 0;
      for (int i = int'(lo); i <= int'(hi); i++) begin
         depth += (bracket_copy[i] == OPEN_BRACKET) ? 1 : -1;
         if (depth < 0) begin
            v.balanced = 1'b0;
            break;
         end
      end
      if (depth != 0) begin
         v.balanced = 1'b0;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      logic        held;
      if (!reset) begin
         // A result beat is retired before a new query is logged in the same cycle.
         if (rsp_valid) begin
            got.balanced  = rsp_balanced;
            got.bad_range = rsp_bad_range;
            if (awaited_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result beat with none awaited: balanced=%b bad_range=%b",
                           $realtime, got.balanced, got.bad_range);
               end
            end else begin
               want = awaited_verdicts.pop_front();
               if (got.balanced !== want.balanced || got.bad_range !== want.bad_range) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected balanced=%b bad_range=%b, got balanced=%b bad_range=%b",
                              $realtime, want.balanced, want.bad_range,
                              got.balanced, got.bad_range);
                  end
               end
            end
         end
         if (start && !busy) begin
            case (req_action)
               ACT_LOAD: begin
                  bracket_copy[req_first_pos] = req_bracket_value;
               end
               ACT_SWAP: begin
                  held = bracket_copy[req_first_pos];
                  bracket_copy[req_first_pos] = bracket_copy[req_last_pos];
                  bracket_copy[req_last_pos]  = held;
               end
               ACT_QUERY: begin
                  awaited_verdicts.push_back(walk_balance(req_first_pos, req_last_pos));
               end
               default: begin
               end
            endcase
         end
      end
      failures    <= mismatch_count;
      outstanding <= awaited_verdicts.size();
   end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

// Stimulus and verdict for the bracket range balance checker. The checker module
// beside the block watches both channels, predicts every query and compares; this
// module only makes the beats, keeps track of which store entries hold a known
// bracket, and prints the outcome.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import brbc_pkg::*;

   localparam int STORE_DEPTH   = 1 << POS_W;
   localparam int ITEM_TARGET   = 580;
   // The final stretch of the run goes without any idling.
   localparam int CALM_TAIL     = 60;
   // For each item, a walk over the whole store plus the longest gap, taken three times over.
   localparam int CYCLE_LIMIT   = ITEM_TARGET * (STORE_DEPTH + 1 + 16 + 8) * 3;
   // After the last result the block may still be walking; a full walk fits in this.
   localparam int SETTLE_CYCLES = STORE_DEPTH + 64;

   // The block ignores this action code and gives no result for it.
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
   localparam logic CLOSE_BRACKET = ~OPEN_BRACKET;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = ACT_LOAD;
   logic [POS_W-1:0]    req_first_pos = '0;
   logic [POS_W-1:0]    req_last_pos = '0;
   logic                req_bracket_value = 1'b0;
   logic                rsp_valid;
   logic                rsp_balanced;
   logic                rsp_bad_range;

   int failures;
   int outstanding;

   // An entry of the store is undefined until it is loaded, so a query must never
   // cover one that has not been. This map follows loads and swaps.
   bit written [STORE_DEPTH];

   int idle_pct = 25;
   int idle_window = 0;
   int cycle_count = 0;
   int n_items = 0;
   int n_loads = 0;
   int n_swaps = 0;
   int n_queries = 0;
   int n_reversed = 0;
   int n_ignored = 0;
   int n_blocks = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bracket_range_balance_checker DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_first_pos     (req_first_pos),
      .req_last_pos      (req_last_pos),
      .req_bracket_value (req_bracket_value),
      .rsp_valid         (rsp_valid),
      .rsp_balanced      (rsp_balanced),
      .rsp_bad_range     (rsp_bad_range)
   );

   balance_verdict_checker verdict_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_first_pos     (req_first_pos),
      .req_last_pos      (req_last_pos),
      .req_bracket_value (req_bracket_value),
      .rsp_valid         (rsp_valid),
      .rsp_balanced      (rsp_balanced),
      .rsp_bad_range     (rsp_bad_range),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   // The watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Drives one beat and returns at the edge that takes it. Busy is read straight
   // after the edge, so it still holds the value that the edge sampled. An idle burst,
   // when one is drawn, is placed before the beat and so falls on whatever phase of
   // the previous action the block is in.
   task automatic send_beat(input logic [ACTION_W-1:0] act, input int first_pos,
                            input int last_pos, input logic value);
      bit held;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_action        <= act;
      req_first_pos     <= POS_W'(first_pos);
      req_last_pos      <= POS_W'(last_pos);
      req_bracket_value <= value;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      case (act)
         ACT_LOAD: begin
            written[first_pos] = 1'b1;
            n_loads++;
         end
         ACT_SWAP: begin
            held = written[first_pos];
            written[first_pos] = written[last_pos];
            written[last_pos]  = held;
            n_swaps++;
         end
         ACT_QUERY: begin
            n_queries++;
            if (first_pos > last_pos) begin
               n_reversed++;
            end
         end
         default: begin
            n_ignored++;
         end
      endcase
      if (act != ACT_UNKNOWN) begin
         n_items++;
      end
   endtask

   // A query whose start lies above its end reads nothing and is always allowed.
   task automatic send_reversed_query();
      int hi;
      hi = $urandom_range(1, STORE_DEPTH - 1);
      send_beat(ACT_QUERY, hi, $urandom_range(0, hi - 1), 1'($urandom_range(0, 1)));
   endtask

   // Writes a random well-formed bracket string at a random place, perhaps spoils it
   // with a swap, and then asks about the whole of it and sometimes about a part.
   task automatic write_balanced_block();
      int   pairs;
      int   base;
      int   opens_left;
      int   depth;
      int   lo;
      int   hi;
      logic br;
      pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      base  = $urandom_range(0, STORE_DEPTH - 2 * pairs);
      opens_left = pairs;
      depth = 0;
      for (int i = 0; i < 2 * pairs; i++) begin
         if (opens_left == 0) begin
            br = CLOSE_BRACKET;
         end else if (depth == 0) begin
            br = OPEN_BRACKET;
         end else begin
            br = $urandom_range(0, 1) ? OPEN_BRACKET : CLOSE_BRACKET;
         end
         if (br == OPEN_BRACKET) begin
            opens_left--;
            depth++;
         end else begin
            depth--;
         end
         send_beat(ACT_LOAD, base + i, $urandom_range(0, STORE_DEPTH - 1), br);
      end
      if ($urandom_range(0, 2) == 0) begin
         send_beat(ACT_SWAP, base + $urandom_range(0, 2 * pairs - 1),
                   base + $urandom_range(0, 2 * pairs - 1), 1'($urandom_range(0, 1)));
      end
      send_beat(ACT_QUERY, base, base + 2 * pairs - 1, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) begin
         lo = base + $urandom_range(0, 2 * pairs - 1);
         hi = $urandom_range(lo, base + 2 * pairs - 1);
         send_beat(ACT_QUERY, lo, hi, 1'($urandom_range(0, 1)));
      end
      n_blocks++;
   endtask

   // Picks a loaded entry and queries from it along the run of loaded entries that
   // follows, mostly short, now and then as long as the run goes.
   task automatic query_written_run();
      int from;
      int till;
      int span;
      from = -1;
      for (int tries = 0; tries < 8 && from < 0; tries++) begin
         till = $urandom_range(0, STORE_DEPTH - 1);
         if (written[till]) begin
            from = till;
         end
      end
      if (from < 0) begin
         send_reversed_query();
      end else begin
         span = ($urandom_range(0, 3) == 0) ? STORE_DEPTH : $urandom_range(1, 16);
         till = from;
         while (till + 1 < STORE_DEPTH && till - from + 1 < span && written[till + 1]) begin
            till++;
         end
         send_beat(ACT_QUERY, from, till, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: the ends of the store, both bracket values, every action,
      // queries that are balanced, that end with open brackets left over, that dip
      // below zero and recover, reversed ranges, a swap of a position with itself
      // and an ignored action code.
      send_beat(ACT_LOAD, 0, STORE_DEPTH - 1, OPEN_BRACKET);
      send_beat(ACT_LOAD, 1, 0, CLOSE_BRACKET);
      send_beat(ACT_LOAD, STORE_DEPTH - 1, 0, CLOSE_BRACKET);
      send_beat(ACT_LOAD, STORE_DEPTH - 2, STORE_DEPTH - 1, OPEN_BRACKET);
      send_beat(ACT_QUERY, 0, 1, 1'b0);
      send_beat(ACT_QUERY, 0, 0, 1'b1);
      send_beat(ACT_QUERY, STORE_DEPTH - 1, STORE_DEPTH - 1, 1'b0);
      send_beat(ACT_QUERY, STORE_DEPTH - 2, STORE_DEPTH - 1, 1'b1);
      send_beat(ACT_QUERY, STORE_DEPTH - 1, 0, 1'b0);
      send_beat(ACT_QUERY, 1, 0, 1'b1);
      send_beat(ACT_SWAP, 0, 1, 1'b0);
      send_beat(ACT_QUERY, 0, 1, 1'b0);
      send_beat(ACT_SWAP, STORE_DEPTH - 1, STORE_DEPTH - 1, 1'b1);
      send_beat(ACT_SWAP, 0, STORE_DEPTH - 1, 1'b0);
      send_beat(ACT_UNKNOWN, STORE_DEPTH - 1, STORE_DEPTH - 1, 1'b1);
      send_beat(ACT_QUERY, 0, 1, 1'b1);
      send_beat(ACT_LOAD, 4, 3, OPEN_BRACKET);
      send_beat(ACT_LOAD, 5, 2, OPEN_BRACKET);
      send_beat(ACT_LOAD, 6, 1, CLOSE_BRACKET);
      send_beat(ACT_LOAD, 7, 0, CLOSE_BRACKET);
      send_beat(ACT_QUERY, 4, 7, 1'b0);
      send_beat(ACT_QUERY, 5, 6, 1'b1);
      send_beat(ACT_QUERY, 4, 6, 1'b0);
      send_beat(ACT_SWAP, 4, 7, 1'b1);
      send_beat(ACT_QUERY, 4, 7, 1'b0);

      // Random part: half of the choices build well-formed strings so that queries
      // reach the balanced answer and the full walk; the rest is scattered loads,
      // swaps, queries over loaded runs, reversed ranges and ignored beats.
      while (n_items < ITEM_TARGET) begin
         if (n_items >= ITEM_TARGET - CALM_TAIL) begin
            idle_pct = 0;
         end else if (n_items / 40 != idle_window) begin
            idle_window = n_items / 40;
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 8;
               2: idle_pct = 25;
               default: idle_pct = 50;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            write_balanced_block();
         end else if (pick < 68) begin
            send_beat(ACT_LOAD, $urandom_range(0, STORE_DEPTH - 1),
                      $urandom_range(0, STORE_DEPTH - 1), 1'($urandom_range(0, 1)));
         end else if (pick < 78) begin
            send_beat(ACT_SWAP, $urandom_range(0, STORE_DEPTH - 1),
                      $urandom_range(0, STORE_DEPTH - 1), 1'($urandom_range(0, 1)));
         end else if (pick < 91) begin
            query_written_run();
         end else if (pick < 96) begin
            send_reversed_query();
         end else begin
            send_beat(ACT_UNKNOWN, $urandom_range(0, STORE_DEPTH - 1),
                      $urandom_range(0, STORE_DEPTH - 1), 1'($urandom_range(0, 1)));
         end
      end
      start <= 1'b0;

      // Let every awaited verdict arrive, then give a walk in flight time to finish
      // so that any stray result beat is still caught.
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d beats: %0d loads, %0d swaps, %0d range queries (%0d reversed).",
               n_items, n_loads, n_swaps, n_queries, n_reversed);
      $display("It built %0d well-formed strings and sent %0d beats of the ignored action.",
               n_blocks, n_ignored);
      if (failures == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/brbc_pkg.sv
rtl/bracket_range_balance_checker.sv
tb/balance_verdict_checker.sv
tb/testbench.sv
